[rtl/i2cas_pkg.sv]
// Package for the I2C address scanner: sequence steps, register indexes and line helpers.
`default_nettype none
package i2cas_pkg;

  // Number of addresses reported per scan by default
  localparam int unsigned MaxDevicesDflt = 24;

  // Width of the reported address count
  localparam int unsigned FoundW = 5;

  // Register indexes on the configuration port
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CfgShortDelay    = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgLongDelay     = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgStretchTimout = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgSettleDelay   = 2'd3;

  // Register reset values
  localparam logic [7:0]  ShortDelayRst     = 8'd2;
  localparam logic [7:0]  LongDelayRst      = 8'd4;
  localparam logic [15:0] StretchTimeoutRst = 16'd5000;
  localparam logic [15:0] SettleDelayRst    = 16'd200;

  // Highest 7-bit address probed
  localparam logic [6:0] LastAddress = 7'h7f;

  // Steps of the probe sequence
  typedef enum logic [4:0] {
    StIdle     = 5'd0,
    StSettle   = 5'd1,
    StIdleBus  = 5'd2,
    StStartLow = 5'd3,
    StClkLow   = 5'd4,
    StBitSet   = 5'd5,
    StBitHigh  = 5'd6,
    StBitLow   = 5'd7,
    StAckRel   = 5'd8,
    StAckHigh  = 5'd9,
    StAckLow   = 5'd10,
    StStopLow  = 5'd11,
    StStopClk  = 5'd12,
    StStopRel  = 5'd13
  } step_e;

  // Line releases as {scl, sda}; 1 releases the line
  typedef logic [1:0] lines_t;
  localparam lines_t LinesReleased = 2'b11;

  // Line releases that a step sets on entry
  function automatic lines_t step_lines(step_e step, logic data_bit);
    lines_t l;
    l = LinesReleased;
    case (step)
      StStartLow:          l = 2'b10;
      StClkLow:            l = 2'b00;
      StBitSet, StBitLow:  l = {1'b0, data_bit};
      StBitHigh:           l = {1'b1, data_bit};
      StAckRel, StAckLow:  l = 2'b01;
      StStopLow:           l = 2'b00;
      StStopClk:           l = 2'b10;
      default:             l = LinesReleased;
    endcase
    return l;
  endfunction

  // The settle, idle-bus, bit-high, ack-high and stop-clock steps release SCL and wait for it to read high first
  function automatic logic step_stretch(step_e step);
    return (step == StSettle) || (step == StIdleBus) || (step == StBitHigh) ||
           (step == StAckHigh) || (step == StStopClk);
  endfunction

endpackage
`default_nettype wire

[rtl/i2c_address_scanner.sv]
// Top level of the I2C address scanner: bit-banged probe of addresses 1 to 127.
`default_nettype none
// One request on the input channel is one tick of the bus timing base (action 0)
// or a scan start (action 1), with the sampled SDA and SCL levels. Each request
// yields exactly one result carrying the line releases to drive, the busy flag,
// any address found on that tick, the running found count and the end-of-scan
// pulse. A request is taken every clock cycle: the sequencer state advances in
// a single pass of logic as the request is accepted, and the result sits in one
// output register that is refilled in the same cycle it is taken, so input
// ready only drops while that register holds a result not yet taken. The result
// is valid in the cycle after its request is taken. Delays and the clock-stretch timeout
// are counted in ticks from the configuration registers, which should be
// written while no request is in flight; a write takes effect from the next
// request, also in the middle of a scan.
module i2c_address_scanner #(
  parameter int unsigned MAX_DEVICES = i2cas_pkg::MaxDevicesDflt
) (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // request channel
  input  wire                            in_valid_i,
  output logic                           in_ready_o,
  input  wire                            action_i,
  input  wire                            sda_level_i,
  input  wire                            scl_level_i,
  // result channel
  output logic                           out_valid_o,
  input  wire                            out_ready_i,
  output logic                           sda_release_o,
  output logic                           scl_release_o,
  output logic                           busy_res_o,
  output logic                           found_valid_o,
  output logic [6:0]                     found_address_o,
  output logic [i2cas_pkg::FoundW-1:0]   found_total_o,
  output logic                           scan_done_o,
  // configuration write channel
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire  [i2cas_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  wire  [15:0]                    cfg_data_i
);

  localparam int unsigned CountCap = (MAX_DEVICES < 31) ? MAX_DEVICES : 31;
  localparam logic [i2cas_pkg::FoundW-1:0] CountCapW = CountCap[i2cas_pkg::FoundW-1:0];
  localparam logic [i2cas_pkg::FoundW-1:0] CountOne  = {{(i2cas_pkg::FoundW-1){1'b0}}, 1'b1};

  // configuration registers
  logic [7:0]  short_delay_q, long_delay_q;
  logic [15:0] stretch_timeout_q, settle_delay_q;

  // sequencer state
  i2cas_pkg::step_e                step_q, step_d;
  logic [2:0]                      bit_pos_q, bit_pos_d;
  logic [6:0]                      probe_q, probe_d;
  logic [15:0]                     wait_q, wait_d;
  logic                            stretch_q, stretch_d;
  logic                            ack_q, ack_d;
  logic [i2cas_pkg::FoundW-1:0]    count_q, count_d;
  i2cas_pkg::lines_t               drive_q, drive_d;

  // per-request outputs
  logic       fvalid, done;
  logic [6:0] faddr;

  logic in_accept, out_accept;

  assign cfg_ready_o = 1'b1;
  assign out_accept  = out_valid_o & out_ready_i;
  assign in_ready_o  = ~out_valid_o | out_ready_i;
  assign in_accept   = in_valid_i & in_ready_o;

  // Take configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      short_delay_q     <= i2cas_pkg::ShortDelayRst;
      long_delay_q      <= i2cas_pkg::LongDelayRst;
      stretch_timeout_q <= i2cas_pkg::StretchTimeoutRst;
      settle_delay_q    <= i2cas_pkg::SettleDelayRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        i2cas_pkg::CfgShortDelay:    short_delay_q     <= cfg_data_i[7:0];
        i2cas_pkg::CfgLongDelay:     long_delay_q      <= cfg_data_i[7:0];
        i2cas_pkg::CfgStretchTimout: stretch_timeout_q <= cfg_data_i;
        i2cas_pkg::CfgSettleDelay:   settle_delay_q    <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Advance the probe sequence by one request
  always_comb begin
    logic [15:0]       wait_inc;
    logic [15:0]       dly_raw;
    logic [15:0]       dly;
    logic              enter;
    i2cas_pkg::step_e  nxt;
    logic [7:0]        addr_byte;

    step_d    = step_q;
    bit_pos_d = bit_pos_q;
    probe_d   = probe_q;
    wait_d    = wait_q;
    stretch_d = stretch_q;
    ack_d     = ack_q;
    count_d   = count_q;
    drive_d   = drive_q;
    fvalid    = 1'b0;
    faddr     = 7'd0;
    done      = 1'b0;
    enter     = 1'b0;
    nxt       = step_q;
    wait_inc  = wait_q + 16'd1;

    // delay of the current step, zero counts as one tick
    case (step_q)
      i2cas_pkg::StSettle: dly_raw = settle_delay_q;
      i2cas_pkg::StIdleBus, i2cas_pkg::StStartLow, i2cas_pkg::StClkLow,
      i2cas_pkg::StBitHigh, i2cas_pkg::StAckHigh, i2cas_pkg::StStopClk,
      i2cas_pkg::StStopRel: dly_raw = {8'd0, long_delay_q};
      default:              dly_raw = {8'd0, short_delay_q};
    endcase
    dly = (dly_raw == 16'd0) ? 16'd1 : dly_raw;

    if (action_i) begin
      // start a scan only from idle
      if (step_q == i2cas_pkg::StIdle) begin
        count_d   = '0;
        probe_d   = 7'd1;
        bit_pos_d = 3'd0;
        ack_d     = 1'b0;
        enter     = 1'b1;
        nxt       = i2cas_pkg::StSettle;
      end
    end else if (step_q != i2cas_pkg::StIdle) begin
      if (stretch_q) begin
        // wait for SCL high or give up at the timeout
        if (scl_level_i) begin
          stretch_d = 1'b0;
          wait_d    = '0;
        end else if (wait_inc >= stretch_timeout_q) begin
          stretch_d = 1'b0;
          wait_d    = '0;
        end else begin
          wait_d    = wait_inc;
        end
      end else begin
        wait_d = wait_inc;
        if (wait_inc >= dly) begin
          unique case (step_q)
            i2cas_pkg::StSettle:   begin enter = 1'b1; nxt = i2cas_pkg::StIdleBus;  end
            i2cas_pkg::StIdleBus:  begin enter = 1'b1; nxt = i2cas_pkg::StStartLow; end
            i2cas_pkg::StStartLow: begin enter = 1'b1; nxt = i2cas_pkg::StClkLow;   end
            i2cas_pkg::StClkLow: begin
              bit_pos_d = 3'd7;
              enter     = 1'b1;
              nxt       = i2cas_pkg::StBitSet;
            end
            i2cas_pkg::StBitSet:   begin enter = 1'b1; nxt = i2cas_pkg::StBitHigh;  end
            i2cas_pkg::StBitHigh:  begin enter = 1'b1; nxt = i2cas_pkg::StBitLow;   end
            i2cas_pkg::StBitLow: begin
              enter = 1'b1;
              if (bit_pos_q == 3'd0) begin
                nxt = i2cas_pkg::StAckRel;
              end else begin
                bit_pos_d = bit_pos_q - 3'd1;
                nxt       = i2cas_pkg::StBitSet;
              end
            end
            i2cas_pkg::StAckRel:   begin enter = 1'b1; nxt = i2cas_pkg::StAckHigh;  end
            i2cas_pkg::StAckHigh: begin
              ack_d = ~sda_level_i;
              enter = 1'b1;
              nxt   = i2cas_pkg::StAckLow;
            end
            i2cas_pkg::StAckLow:   begin enter = 1'b1; nxt = i2cas_pkg::StStopLow;  end
            i2cas_pkg::StStopLow:  begin enter = 1'b1; nxt = i2cas_pkg::StStopClk;  end
            i2cas_pkg::StStopClk:  begin enter = 1'b1; nxt = i2cas_pkg::StStopRel;  end
            i2cas_pkg::StStopRel: begin
              // report an acknowledge while the list has room
              if (ack_q && (count_q < CountCapW)) begin
                fvalid  = 1'b1;
                faddr   = probe_q;
                count_d = count_q + CountOne;
              end
              ack_d = 1'b0;
              if (probe_q == i2cas_pkg::LastAddress) begin
                done      = 1'b1;
                step_d    = i2cas_pkg::StIdle;
                stretch_d = 1'b0;
                wait_d    = '0;
                drive_d   = i2cas_pkg::LinesReleased;
              end else begin
                probe_d = probe_q + 7'd1;
                enter   = 1'b1;
                nxt     = i2cas_pkg::StIdleBus;
              end
            end
            default: begin
              step_d    = i2cas_pkg::StIdle;
              stretch_d = 1'b0;
              wait_d    = '0;
              drive_d   = i2cas_pkg::LinesReleased;
            end
          endcase
        end
      end
    end

    // set the lines of a new step and arm its stretch wait
    addr_byte = {probe_d, 1'b0};
    if (enter) begin
      step_d    = nxt;
      drive_d   = i2cas_pkg::step_lines(nxt, addr_byte[bit_pos_d]);
      stretch_d = i2cas_pkg::step_stretch(nxt);
      wait_d    = '0;
    end
  end

  // Hold sequencer state, advance on each accepted request
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q    <= i2cas_pkg::StIdle;
      bit_pos_q <= 3'd0;
      probe_q   <= 7'd0;
      wait_q    <= 16'd0;
      stretch_q <= 1'b0;
      ack_q     <= 1'b0;
      count_q   <= '0;
      drive_q   <= i2cas_pkg::LinesReleased;
    end else if (in_accept) begin
      step_q    <= step_d;
      bit_pos_q <= bit_pos_d;
      probe_q   <= probe_d;
      wait_q    <= wait_d;
      stretch_q <= stretch_d;
      ack_q     <= ack_d;
      count_q   <= count_d;
      drive_q   <= drive_d;
    end
  end

  // Result valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (in_accept) begin
      out_valid_o <= 1'b1;
    end else if (out_accept) begin
      out_valid_o <= 1'b0;
    end
  end

  // Result payload
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      sda_release_o   <= drive_d[0];
      scl_release_o   <= drive_d[1];
      busy_res_o      <= (step_d != i2cas_pkg::StIdle);
      found_valid_o   <= fvalid;
      found_address_o <= faddr;
      found_total_o   <= count_d;
      scan_done_o     <= done;
    end
  end

`ifndef SYNTH
  // an accepted request always leaves a result
  a_result_after_accept: assert property (
    @(posedge clk_i) disable iff (!rst_ni) in_accept |=> out_valid_o)
    else $error("result missing after accepted request");

  // the end of a scan leaves the block idle
  a_done_idle: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (out_valid_o && scan_done_o) |-> !busy_res_o)
    else $error("scan done while still busy");

  // both lines are released whenever no scan runs
  a_idle_released: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !busy_res_o) |-> (sda_release_o && scl_release_o))
    else $error("line driven while idle");

  // a reported address is counted and never exceeds the cap
  a_found_counted: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_valid_o) |-> (found_total_o != '0 && found_address_o != 7'd0))
    else $error("found address not counted");

  a_count_cap: assert property (
    @(posedge clk_i) disable iff (!rst_ni) count_q <= CountCapW)
    else $error("found count above cap");
`endif

endmodule
`default_nettype wire

[verif/i2c_address_scanner_tb.sv]
// Testbench for the I2C address scanner: paced requests checked against a tick-level model.
`timescale 1ns / 100ps

module i2c_address_scanner_tb;

  localparam int unsigned MaxFound    = i2cas_pkg::MaxDevicesDflt;
  localparam int unsigned FoundCapInt = (MaxFound < 31) ? MaxFound : 31;
  localparam logic [4:0]  FoundCap    = FoundCapInt[4:0];
  localparam int unsigned StallLimit  = 1000;

  // One request: a tick or a scan start, with the sampled bus levels
  typedef struct packed {
    logic act;
    logic sda;
    logic scl;
  } tick_t;

  // One expected result of the scanner
  typedef struct packed {
    logic       sda_rel;
    logic       scl_rel;
    logic       busy;
    logic       found;
    logic [6:0] addr;
    logic [4:0] total;
    logic       done;
  } scan_result_t;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  logic        in_valid  = 1'b0;
  logic        in_action = 1'b0;
  logic        in_sda    = 1'b1;
  logic        in_scl    = 1'b1;
  logic        out_ready = 1'b0;
  logic        cfg_valid = 1'b0;
  logic [i2cas_pkg::CfgIdxW-1:0] cfg_index = i2cas_pkg::CfgShortDelay;
  logic [15:0] cfg_data  = 16'd0;

  wire         in_ready_o;
  wire         out_valid_o;
  wire         sda_release_o;
  wire         scl_release_o;
  wire         busy_res_o;
  wire         found_valid_o;
  wire [6:0]   found_address_o;
  wire [i2cas_pkg::FoundW-1:0] found_total_o;
  wire         scan_done_o;
  wire         cfg_ready_o;

  i2c_address_scanner #(
    .MAX_DEVICES(MaxFound)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid),
    .in_ready_o     (in_ready_o),
    .action_i       (in_action),
    .sda_level_i    (in_sda),
    .scl_level_i    (in_scl),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready),
    .sda_release_o  (sda_release_o),
    .scl_release_o  (scl_release_o),
    .busy_res_o     (busy_res_o),
    .found_valid_o  (found_valid_o),
    .found_address_o(found_address_o),
    .found_total_o  (found_total_o),
    .scan_done_o    (scan_done_o),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  // Clock: 4 ns period
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Model copy of the timing registers
  logic [7:0]  short_ticks   = i2cas_pkg::ShortDelayRst;
  logic [7:0]  long_ticks    = i2cas_pkg::LongDelayRst;
  logic [15:0] stretch_limit = i2cas_pkg::StretchTimeoutRst;
  logic [15:0] settle_ticks  = i2cas_pkg::SettleDelayRst;

  // Model copy of the sequencer state
  i2cas_pkg::step_e scan_step = i2cas_pkg::StIdle;
  logic [2:0]  bit_idx     = 3'd0;
  logic [6:0]  probe_addr  = 7'd0;
  logic [15:0] tick_cnt    = 16'd0;
  logic        stretch_on  = 1'b0;
  logic        ack_pending = 1'b0;
  logic [4:0]  found_cnt   = 5'd0;
  logic        line_sda    = 1'b1;
  logic        line_scl    = 1'b1;

  tick_t        tick_q[$];
  scan_result_t probe_results_q[$];
  int unsigned  mismatches = 0;

  // Ticks that a step lasts once any stretch wait is over
  function automatic logic [15:0] hold_ticks(i2cas_pkg::step_e s);
    logic [15:0] d;
    case (s)
      i2cas_pkg::StSettle: d = settle_ticks;
      i2cas_pkg::StIdleBus, i2cas_pkg::StStartLow, i2cas_pkg::StClkLow,
      i2cas_pkg::StBitHigh, i2cas_pkg::StAckHigh, i2cas_pkg::StStopClk,
      i2cas_pkg::StStopRel:
        d = {8'd0, long_ticks};
      default: d = {8'd0, short_ticks};
    endcase
    return (d == 16'd0) ? 16'd1 : d;
  endfunction

  // Enter a step: set both lines, arm the stretch wait, clear the count
  function automatic void enter_step(i2cas_pkg::step_e s);
    logic [7:0] frame;
    logic       b;
    frame = {probe_addr, 1'b0};
    b = frame[bit_idx];
    line_sda = 1'b1;
    line_scl = 1'b1;
    case (s)
      i2cas_pkg::StStartLow: line_sda = 1'b0;
      i2cas_pkg::StClkLow, i2cas_pkg::StStopLow: begin
        line_sda = 1'b0;
        line_scl = 1'b0;
      end
      i2cas_pkg::StBitSet, i2cas_pkg::StBitLow: begin
        line_sda = b;
        line_scl = 1'b0;
      end
      i2cas_pkg::StBitHigh: line_sda = b;
      i2cas_pkg::StAckRel, i2cas_pkg::StAckLow: line_scl = 1'b0;
      i2cas_pkg::StStopClk: line_sda = 1'b0;
      default: ;
    endcase
    scan_step  = s;
    stretch_on = (s == i2cas_pkg::StSettle) || (s == i2cas_pkg::StIdleBus) ||
                 (s == i2cas_pkg::StBitHigh) || (s == i2cas_pkg::StAckHigh) ||
                 (s == i2cas_pkg::StStopClk);
    tick_cnt   = 16'd0;
  endfunction

  // Advance the model by one request and return the result it causes
  function automatic scan_result_t advance_scan(logic act, logic sda, logic scl);
    scan_result_t r;
    r = '0;
    if (act) begin
      if (scan_step == i2cas_pkg::StIdle) begin
        found_cnt   = 5'd0;
        probe_addr  = 7'd1;
        bit_idx     = 3'd0;
        ack_pending = 1'b0;
        enter_step(i2cas_pkg::StSettle);
      end
    end else if (scan_step != i2cas_pkg::StIdle) begin
      if (stretch_on) begin
        if (scl) begin
          stretch_on = 1'b0;
          tick_cnt   = 16'd0;
        end else begin
          tick_cnt = tick_cnt + 16'd1;
          if (tick_cnt >= stretch_limit) begin
            stretch_on = 1'b0;
            tick_cnt   = 16'd0;
          end
        end
      end else begin
        tick_cnt = tick_cnt + 16'd1;
        if (tick_cnt >= hold_ticks(scan_step)) begin
          case (scan_step)
            i2cas_pkg::StSettle:   enter_step(i2cas_pkg::StIdleBus);
            i2cas_pkg::StIdleBus:  enter_step(i2cas_pkg::StStartLow);
            i2cas_pkg::StStartLow: enter_step(i2cas_pkg::StClkLow);
            i2cas_pkg::StClkLow: begin
              bit_idx = 3'd7;
              enter_step(i2cas_pkg::StBitSet);
            end
            i2cas_pkg::StBitSet:   enter_step(i2cas_pkg::StBitHigh);
            i2cas_pkg::StBitHigh:  enter_step(i2cas_pkg::StBitLow);
            i2cas_pkg::StBitLow: begin
              if (bit_idx == 3'd0) begin
                enter_step(i2cas_pkg::StAckRel);
              end else begin
                bit_idx = bit_idx - 3'd1;
                enter_step(i2cas_pkg::StBitSet);
              end
            end
            i2cas_pkg::StAckRel: enter_step(i2cas_pkg::StAckHigh);
            i2cas_pkg::StAckHigh: begin
              ack_pending = !sda;
              enter_step(i2cas_pkg::StAckLow);
            end
            i2cas_pkg::StAckLow:  enter_step(i2cas_pkg::StStopLow);
            i2cas_pkg::StStopLow: enter_step(i2cas_pkg::StStopClk);
            i2cas_pkg::StStopClk: enter_step(i2cas_pkg::StStopRel);
            i2cas_pkg::StStopRel: begin
              // report the acknowledge unless the list is already full
              if (ack_pending && found_cnt < FoundCap) begin
                r.found   = 1'b1;
                r.addr    = probe_addr;
                found_cnt = found_cnt + 5'd1;
              end
              ack_pending = 1'b0;
              if (probe_addr == i2cas_pkg::LastAddress) begin
                r.done     = 1'b1;
                scan_step  = i2cas_pkg::StIdle;
                stretch_on = 1'b0;
                tick_cnt   = 16'd0;
                line_sda   = 1'b1;
                line_scl   = 1'b1;
              end else begin
                probe_addr = probe_addr + 7'd1;
                enter_step(i2cas_pkg::StIdleBus);
              end
            end
            default: ;
          endcase
        end
      end
    end
    r.sda_rel = line_sda;
    r.scl_rel = line_scl;
    r.busy    = (scan_step != i2cas_pkg::StIdle);
    r.total   = found_cnt;
    return r;
  endfunction

  // Record a register write in the model
  function automatic void store_reg(logic [i2cas_pkg::CfgIdxW-1:0] idx, logic [15:0] val);
    case (idx)
      i2cas_pkg::CfgShortDelay:    short_ticks   = val[7:0];
      i2cas_pkg::CfgLongDelay:     long_ticks    = val[7:0];
      i2cas_pkg::CfgStretchTimout: stretch_limit = val;
      i2cas_pkg::CfgSettleDelay:   settle_ticks  = val;
      default: ;
    endcase
  endfunction

  function automatic void check_field(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  // Request driver: hold each request until taken, then idle for a drawn gap
  tick_t       tx_next;
  logic [3:0]  tx_gap  = 4'd0;
  logic        tx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid <= 1'b0;
      tx_gap   <= 4'd0;
      tx_calm  <= 1'b0;
    end else begin
      if (in_valid && in_ready_o) begin
        probe_results_q.push_back(advance_scan(in_action, in_sda, in_scl));
      end
      if ($urandom_range(0, 63) == 0) begin
        tx_calm <= !tx_calm;
      end
      if (!in_valid || in_ready_o) begin
        if (tx_gap != 4'd0) begin
          in_valid <= 1'b0;
          tx_gap   <= tx_gap - 4'd1;
        end else if (tick_q.size() != 0) begin
          tx_next   = tick_q.pop_front();
          in_action <= tx_next.act;
          in_sda    <= tx_next.sda;
          in_scl    <= tx_next.scl;
          in_valid  <= 1'b1;
          tx_gap    <= tx_calm ? 4'd0 : 4'($urandom_range(0, 14));
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor: compare each result with the oldest expectation, stall at random
  scan_result_t rx_want;
  logic [3:0]   rx_wait = 4'd0;
  logic [3:0]   rx_draw;
  logic         rx_calm = 1'b0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      rx_wait   <= 4'd0;
      rx_calm   <= 1'b0;
    end else begin
      if ($urandom_range(0, 63) == 0) begin
        rx_calm <= !rx_calm;
      end
      if (out_valid_o && out_ready) begin
        if (probe_results_q.size() == 0) begin
          $error("result arrived with nothing expected");
          mismatches++;
        end else begin
          rx_want = probe_results_q.pop_front();
          check_field("sda_release", 8'(rx_want.sda_rel), 8'(sda_release_o));
          check_field("scl_release", 8'(rx_want.scl_rel), 8'(scl_release_o));
          check_field("busy_res", 8'(rx_want.busy), 8'(busy_res_o));
          check_field("found_valid", 8'(rx_want.found), 8'(found_valid_o));
          check_field("found_address", 8'(rx_want.addr), 8'(found_address_o));
          check_field("found_total", 8'(rx_want.total), 8'(found_total_o));
          check_field("scan_done", 8'(rx_want.done), 8'(scan_done_o));
        end
        rx_draw = rx_calm ? 4'd0 : 4'($urandom_range(0, 14));
        if (rx_draw == 4'd0) begin
          out_ready <= 1'b1;
        end else begin
          out_ready <= 1'b0;
          rx_wait   <= rx_draw - 4'd1;
        end
      end else if (!out_ready) begin
        if (rx_wait == 4'd0) begin
          out_ready <= 1'b1;
        end else begin
          rx_wait <= rx_wait - 4'd1;
        end
      end
    end
  end

  // Watchdog: stop the run when no request, result or write moves for too long
  int unsigned quiet_cycles = 0;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((in_valid && in_ready_o) || (out_valid_o && out_ready) ||
                 (cfg_valid && cfg_ready_o)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == StallLimit) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  function automatic logic coin();
    return 1'($urandom_range(0, 1));
  endfunction

  function automatic logic odds(int unsigned pct);
    return ($urandom_range(0, 99) < pct);
  endfunction

  function automatic void push_tick(logic act, logic sda, logic scl);
    tick_t t;
    t.act = act;
    t.sda = sda;
    t.scl = scl;
    tick_q.push_back(t);
  endfunction

  // Hold the sender until every request is taken and every result is back
  task automatic drain();
    while (tick_q.size() != 0 || in_valid || probe_results_q.size() != 0) begin
      @(negedge clk_i);
    end
  endtask

  // Write all four timing registers back to back
  task automatic program_timing(input logic [7:0] sd, input logic [7:0] ld,
                                input logic [15:0] st, input logic [15:0] sl);
    logic [i2cas_pkg::CfgIdxW-1:0] idx[4];
    logic [15:0]                   val[4];
    int                            k;
    idx[0] = i2cas_pkg::CfgShortDelay;    val[0] = {8'd0, sd};
    idx[1] = i2cas_pkg::CfgLongDelay;     val[1] = {8'd0, ld};
    idx[2] = i2cas_pkg::CfgStretchTimout; val[2] = st;
    idx[3] = i2cas_pkg::CfgSettleDelay;   val[3] = sl;
    @(posedge clk_i);
    for (k = 0; k < 4; k++) begin
      cfg_valid <= 1'b1;
      cfg_index <= idx[k];
      cfg_data  <= val[k];
      @(posedge clk_i);
      while (!cfg_ready_o) begin
        @(posedge clk_i);
      end
      store_reg(idx[k], val[k]);
    end
    cfg_valid <= 1'b0;
  endtask

  // Queue a run of ticks with drawn bus levels; a rough run also drops in
  // starts, which the running scan ignores, and pauses once halfway
  task automatic pump(input int unsigned count, input int unsigned ack_pct,
                      input int unsigned low_pct, input bit rough);
    int unsigned k;
    for (k = 0; k < count; k++) begin
      if (rough && k == count / 2) begin
        drain();
      end
      if (rough && $urandom_range(0, 99) == 0) begin
        push_tick(1'b1, coin(), coin());
      end else begin
        push_tick(1'b0, !odds(ack_pct), !odds(low_pct));
      end
    end
  endtask

  // Reset: hold at the start, then release once
  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  // Stimulus and end of run
  initial begin
    int n;
    wait (rst_ni);
    @(negedge clk_i);

    // idle ticks at reset settings, every level pair
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    drain();

    // largest settings while idle
    program_timing(8'd255, 8'd255, 16'd65535, 16'd65535);
    @(negedge clk_i);
    for (n = 0; n < 24; n++) begin
      push_tick(1'b0, coin(), coin());
    end
    drain();

    // zero delays and zero timeout, then a walk through the opening steps
    program_timing(8'd0, 8'd0, 16'd0, 16'd0);
    @(negedge clk_i);
    push_tick(1'b1, 1'b1, 1'b1);
    push_tick(1'b1, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b0, 1'b0);
    push_tick(1'b0, 1'b1, 1'b0);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b1, 1'b1);
    push_tick(1'b0, 1'b0, 1'b0);

    // carry on through the first addresses with most of them acknowledging
    pump(340, 88, 6, 1'b0);
    drain();

    // short settings, clock stretching and a sparse bus
    program_timing(8'($urandom_range(1, 2)), 8'($urandom_range(1, 2)),
                   16'($urandom_range(1, 6)), 16'($urandom_range(0, 30)));
    @(negedge clk_i);
    pump(240, 15, 30, 1'b1);
    drain();

    // longest step delays, stretch waits mostly ended by SCL reading high before the timeout
    program_timing(8'd255, 8'd255, 16'd40, 16'd0);
    @(negedge clk_i);
    pump(300, 50, 80, 1'b0);
    drain();

    repeat (8) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

[files.f]
rtl/i2cas_pkg.sv
rtl/i2c_address_scanner.sv
verif/i2c_address_scanner_tb.sv
